[hw/rtl/c2dzp_pkg.sv]
// Shared types and constants of the streaming 3x3-style zero-padded convolution.
// Used by every module of the block; depends on nothing.
`default_nettype none

package c2dzp_pkg;

	localparam int KERNEL_SIZE_DEF = 3;
	localparam int MAX_WIDTH_DEF   = 32;
	localparam int PIXEL_BITS      = 16;
	localparam int COEF_BITS       = 16;
	localparam int OUT_BITS        = 40;
	localparam int DIM_BITS        = 6;
	localparam int IDX_BITS        = 4;
	localparam int CFG_IDX_BITS    = 1;
	localparam int QUEUE_DEPTH     = 4;
	localparam int ENTRY_DATA_BITS = (PIXEL_BITS > COEF_BITS) ? PIXEL_BITS : COEF_BITS;

	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(28);

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [0:0] {
		OP_COEF  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef logic signed [PIXEL_BITS-1:0] pix_t;
	typedef logic signed [COEF_BITS-1:0]  coef_t;

	typedef struct packed {
		op_t                   operation;
		logic [IDX_BITS-1:0]   coef_index;
		logic signed [COEF_BITS-1:0]  coef_value;
		logic signed [PIXEL_BITS-1:0] pixel_value;
	} in_req_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] out_value;
		logic                       out_last;
	} out_res_t;

	// effective frame geometry, constant while a frame runs
	typedef struct packed {
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
	} geom_t;

	// one classified request between front and back
	typedef struct packed {
		op_t                        operation;
		logic [IDX_BITS-1:0]        coef_index;
		logic [ENTRY_DATA_BITS-1:0] data;
		logic [DIM_BITS-1:0]        col;
		logic [DIM_BITS-1:0]        orow;
		logic [DIM_BITS-1:0]        ocol;
		logic                       emit;
		logic                       last;
	} entry_t;

endpackage

`default_nettype wire

[hw/rtl/c2dzp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on c2dzp_pkg for default sizes.
`default_nettype none

module c2dzp_ram #(
	parameter int WIDTH = c2dzp_pkg::PIXEL_BITS,
	parameter int DEPTH = c2dzp_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/c2dzp_queue.sv]
// Short request queue that decouples front and back.
// Depends on c2dzp_pkg (entry_t, QUEUE_DEPTH).
`default_nettype none

module c2dzp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  c2dzp_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output c2dzp_pkg::entry_t head
);
	import c2dzp_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/c2dzp_front.sv]
// Front end: config registers, frame position counters, request classification
// and end-of-frame flush generation. Depends on c2dzp_pkg.
`default_nettype none

module c2dzp_front #(
	parameter int KERNEL_SIZE = c2dzp_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = c2dzp_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [c2dzp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [c2dzp_pkg::DIM_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  c2dzp_pkg::in_req_t                in_data,
	input  logic                              q_full,
	output logic                              q_push,
	output c2dzp_pkg::entry_t                 q_entry,
	output c2dzp_pkg::geom_t                  geom
);
	import c2dzp_pkg::*;

	localparam int HALF_K   = KERNEL_SIZE / 2;
	localparam int TAPS     = KERNEL_SIZE * KERNEL_SIZE;
	localparam int LAG_MAX  = HALF_K * MAX_WIDTH + HALF_K;
	localparam int LAG_BITS = $clog2(LAG_MAX + 2);

	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic [DIM_BITS-1:0] qc_q;
	logic [DIM_BITS-1:0] qr_q;
	logic [DIM_BITS-1:0] orow_q;
	logic [DIM_BITS-1:0] ocol_q;
	logic [LAG_BITS-1:0] fill_q;
	logic [LAG_BITS-1:0] flush_cnt_q;
	logic                flushing_q;

	logic [DIM_BITS-1:0] w_eff;
	logic [DIM_BITS-1:0] h_eff;
	logic [LAG_BITS-1:0] lag;
	logic                accept;
	logic                step;
	logic                emit;
	logic                qc_end;
	logic                ocol_end;
	logic                frame_end;
	logic                restart;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_BITS'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = DIM_BITS'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == '0) ? DIM_BITS'(1) : height_q;
	end

	assign geom.w = w_eff;
	assign geom.h = h_eff;
	assign lag    = LAG_BITS'(HALF_K * int'(w_eff) + HALF_K);

	assign in_stall  = q_full || flushing_q;
	assign accept    = in_valid && !in_stall;
	// a pixel position advances on a pixel request or on a flush slot
	assign step      = flushing_q ? !q_full : (accept && in_data.operation == OP_PIXEL);
	assign emit      = (fill_q == lag);
	assign qc_end    = (qc_q == w_eff - DIM_BITS'(1));
	assign ocol_end  = (ocol_q == w_eff - DIM_BITS'(1));
	assign frame_end = !flushing_q && qc_end && (qr_q == h_eff - DIM_BITS'(1));
	// last flush slot, or last pixel when there is nothing to flush
	assign restart   = flushing_q ? (flush_cnt_q == LAG_BITS'(1)) : (frame_end && lag == '0);

	// out-of-range coefficient loads are dropped here
	assign q_push = step || (accept && in_data.operation == OP_COEF &&
		int'(in_data.coef_index) < TAPS);

	always_comb begin
		q_entry            = '0;
		q_entry.operation  = flushing_q ? OP_PIXEL : in_data.operation;
		q_entry.coef_index = in_data.coef_index;
		if (flushing_q) begin
			q_entry.data = '0;
		end else if (in_data.operation == OP_COEF) begin
			q_entry.data = ENTRY_DATA_BITS'(in_data.coef_value);
		end else begin
			q_entry.data = ENTRY_DATA_BITS'(in_data.pixel_value);
		end
		q_entry.col  = qc_q;
		q_entry.orow = orow_q;
		q_entry.ocol = ocol_q;
		q_entry.emit = emit;
		q_entry.last = emit && ocol_end && (orow_q == h_eff - DIM_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= DIM_RESET;
			height_q    <= DIM_RESET;
			qc_q        <= '0;
			qr_q        <= '0;
			orow_q      <= '0;
			ocol_q      <= '0;
			fill_q      <= '0;
			flush_cnt_q <= '0;
			flushing_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
			qc_q       <= '0;
			qr_q       <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			fill_q     <= '0;
			flushing_q <= 1'b0;
		end else if (step) begin
			if (restart) begin
				qc_q       <= '0;
				qr_q       <= '0;
				orow_q     <= '0;
				ocol_q     <= '0;
				fill_q     <= '0;
				flushing_q <= 1'b0;
			end else begin
				if (emit) begin
					if (ocol_end) begin
						ocol_q <= '0;
						orow_q <= orow_q + DIM_BITS'(1);
					end else begin
						ocol_q <= ocol_q + DIM_BITS'(1);
					end
				end else begin
					fill_q <= fill_q + LAG_BITS'(1);
				end
				qc_q <= qc_end ? '0 : qc_q + DIM_BITS'(1);
				if (flushing_q) begin
					flush_cnt_q <= flush_cnt_q - LAG_BITS'(1);
				end else if (frame_end) begin
					qr_q        <= '0;
					flushing_q  <= 1'b1;
					flush_cnt_q <= lag;
				end else if (qc_end) begin
					qr_q <= qr_q + DIM_BITS'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/c2dzp_back.sv]
// Back end: line buffer RAM, window register, masked multiplies and adder tree.
// Depends on c2dzp_pkg and c2dzp_ram.
`default_nettype none

module c2dzp_back #(
	parameter int KERNEL_SIZE = c2dzp_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = c2dzp_pkg::MAX_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  c2dzp_pkg::geom_t   geom,
	input  logic               q_valid,
	input  c2dzp_pkg::entry_t  q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output c2dzp_pkg::out_res_t out_data
);
	import c2dzp_pkg::*;

	localparam int HALF_K    = KERNEL_SIZE / 2;
	localparam int TAPS      = KERNEL_SIZE * KERNEL_SIZE;
	localparam int AW        = $clog2(MAX_WIDTH);
	localparam int LB_ROWS   = KERNEL_SIZE - 1;
	localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;

	logic en;

	logic   v_s1;
	entry_t e_s1;
	logic   v_s2;
	entry_t e_s2;
	logic   v_s3;
	logic   last_s3;
	logic   v_s4;
	logic   last_s4;
	logic   out_valid_q;
	out_res_t out_q;

	pix_t  col_px [KERNEL_SIZE];
	pix_t  win_q  [KERNEL_SIZE][KERNEL_SIZE];
	coef_t kern_q [TAPS];
	logic  win_shift;

	logic signed [PROD_BITS-1:0] prod_s3 [TAPS];
	logic signed [OUT_BITS-1:0]  rsum_s4 [KERNEL_SIZE];
	logic signed [OUT_BITS-1:0]  total;

	// the whole back pipeline moves unless a finished result is held
	assign en        = !out_valid_q || !out_stall;
	assign q_pop     = en && q_valid;
	assign win_shift = en && v_s1 && (e_s1.operation == OP_PIXEL);

	assign col_px[0] = pix_t'(e_s1.data[PIXEL_BITS-1:0]);

	generate
		if (LB_ROWS > 0) begin : g_lb
			localparam int LB_BITS = LB_ROWS * PIXEL_BITS;

			logic [LB_BITS-1:0] lb_rdata;
			logic [LB_BITS-1:0] lb_wdata;
			logic [LB_BITS-1:0] lb_word;
			logic [LB_BITS-1:0] fwd_data_q;
			logic               fwd_q;
			logic [AW-1:0]      raddr;
			logic [AW-1:0]      waddr;

			assign raddr = q_head.col[AW-1:0];
			assign waddr = e_s1.col[AW-1:0];
			// width-1 rows rewrite the entry just read: forward it
			assign lb_word = fwd_q ? fwd_data_q : lb_rdata;

			for (genvar d = 1; d < KERNEL_SIZE; d++) begin : g_col
				assign col_px[d] = pix_t'(lb_word[(d-1)*PIXEL_BITS +: PIXEL_BITS]);
			end
			for (genvar d = 0; d < LB_ROWS; d++) begin : g_wr
				assign lb_wdata[d*PIXEL_BITS +: PIXEL_BITS] = col_px[d];
			end

			c2dzp_ram #(
				.WIDTH (LB_BITS),
				.DEPTH (MAX_WIDTH)
			) u_lb_ram (
				.clk   (clk),
				.we    (win_shift),
				.waddr (waddr),
				.wdata (lb_wdata),
				.re    (q_pop),
				.raddr (raddr),
				.rdata (lb_rdata)
			);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					fwd_q <= 1'b0;
				end else if (en) begin
					fwd_q <= win_shift && q_pop && (raddr == waddr);
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					fwd_data_q <= lb_wdata;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int t = 0; t < TAPS; t++) begin
				kern_q[t] <= '0;
			end
		end else if (en) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && (e_s2.operation == OP_PIXEL) && e_s2.emit;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
			if (v_s2 && e_s2.operation == OP_COEF) begin
				for (int t = 0; t < TAPS; t++) begin
					if (int'(e_s2.coef_index) == t) begin
						kern_q[t] <= coef_t'(e_s2.data[COEF_BITS-1:0]);
					end
				end
			end
		end
	end

	// window: column 0 oldest, row 0 topmost
	always_ff @(posedge clk) begin
		if (win_shift) begin
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
				win_q[i][KERNEL_SIZE-1] <= col_px[KERNEL_SIZE-1-i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= q_head;
			e_s2 <= e_s1;
		end
	end

	// multiply stage, taps outside the image read as zero
	always_ff @(posedge clk) begin
		if (en) begin
			last_s3 <= e_s2.last;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					logic row_ok;
					logic col_ok;
					pix_t px_m;
					row_ok = (int'(e_s2.orow) + i >= HALF_K) &&
						(int'(e_s2.orow) + i < int'(geom.h) + HALF_K);
					col_ok = (int'(e_s2.ocol) + j >= HALF_K) &&
						(int'(e_s2.ocol) + j < int'(geom.w) + HALF_K);
					px_m = (row_ok && col_ok) ? win_q[i][j] : '0;
					prod_s3[i*KERNEL_SIZE+j] <= px_m * kern_q[i*KERNEL_SIZE+j];
				end
			end
		end
	end

	// row sums
	always_ff @(posedge clk) begin
		if (en) begin
			last_s4 <= last_s3;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				logic signed [OUT_BITS-1:0] acc;
				acc = '0;
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					acc = acc + OUT_BITS'(prod_s3[i*KERNEL_SIZE+j]);
				end
				rsum_s4[i] <= acc;
			end
		end
	end

	always_comb begin
		total = '0;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			total = total + rsum_s4[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.out_value <= total;
			out_q.out_last  <= last_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[hw/rtl/conv2d_same_zero_pad.sv]
// Streaming same-size 2D correlation with zero padding. Top level.
// Depends on c2dzp_pkg, c2dzp_front, c2dzp_queue, c2dzp_back.
//
// Pixel and coefficient requests are taken one per clock while the short
// request queue has room and no flush is running. A request passes from the
// queue through stages s1 and s2, then the multiply, row-sum and output
// registers; out_stall holds the pipeline, and results can follow one per
// clock while it is low. After the last pixel of a frame the front inserts
// L = (KERNEL_SIZE/2)*W + KERNEL_SIZE/2 flush slots (W = effective width) to
// drain the final row; in_stall stays high until those L slots have entered
// the queue. The previous rows live in one line buffer RAM of MAX_WIDTH
// entries holding KERNEL_SIZE-1 rows side by side; all KERNEL_SIZE^2
// multiplies run in parallel. Write the image registers only when idle: a
// write restarts the frame.
`default_nettype none

module conv2d_same_zero_pad #(
	parameter int KERNEL_SIZE = c2dzp_pkg::KERNEL_SIZE_DEF,
	parameter int MAX_WIDTH   = c2dzp_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [c2dzp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [c2dzp_pkg::DIM_BITS-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  c2dzp_pkg::in_req_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output c2dzp_pkg::out_res_t                out_data
);
	import c2dzp_pkg::*;

	logic   q_full;
	logic   q_push;
	entry_t q_entry;
	logic   q_pop;
	logic   q_valid;
	entry_t q_head;
	geom_t  geom;

	c2dzp_front #(
		.KERNEL_SIZE (KERNEL_SIZE),
		.MAX_WIDTH   (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry),
		.geom      (geom)
	);

	c2dzp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	c2dzp_back #(
		.KERNEL_SIZE (KERNEL_SIZE),
		.MAX_WIDTH   (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[tb/conv2d_same_zero_pad_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for conv2d_same_zero_pad: directed coefficient and geometry cases,
// a dropped frame, a long output hold and random frames, all checked against a
// behavioral 2D correlation kept in the bench. Depends on c2dzp_pkg and the block's RTL.

module conv2d_same_zero_pad_tb;
	import c2dzp_pkg::*;

	localparam int KSZ          = KERNEL_SIZE_DEF;
	localparam int HALF         = KSZ / 2;
	localparam int TAPS         = KSZ * KSZ;
	localparam int FRAME_MAX    = MAX_WIDTH_DEF * 64;
	localparam int SETTLE       = 24;
	localparam int LONG_HOLD    = 400;
	localparam int RANDOM_ITEMS = 170;
	localparam int CYCLE_LIMIT  = 300000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_write;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [DIM_BITS-1:0]     cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	in_req_t                 in_data;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	out_res_t                out_data;

	conv2d_same_zero_pad u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #10 clk = ~clk;

	// convolution predictor state
	coef_t               kernel_taps [TAPS];
	pix_t                frame_pix [FRAME_MAX];
	logic [DIM_BITS-1:0] img_w_raw = DIM_RESET;
	logic [DIM_BITS-1:0] img_h_raw = DIM_RESET;
	int                  pix_pos = 0;
	out_res_t            expected_results [$];

	int mismatch_count     = 0;
	int accepted_count     = 0;
	int results_checked    = 0;
	int geometry_writes    = 0;
	int cycle_count        = 0;
	bit idle_enable        = 1'b1;
	int long_hold_requests = 0;
	int long_holds_served  = 0;

	function automatic int cols_of(input logic [DIM_BITS-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return raw;
	endfunction

	function automatic int rows_of(input logic [DIM_BITS-1:0] raw);
		return (raw == 0) ? 1 : raw;
	endfunction

	function automatic out_res_t conv_at(input int idx);
		int w, h, r, c, rr, cc, i, j;
		longint acc;
		out_res_t res;
		w   = cols_of(img_w_raw);
		h   = rows_of(img_h_raw);
		r   = idx / w;
		c   = idx % w;
		acc = 0;
		for (i = 0; i < KSZ; i++)
			for (j = 0; j < KSZ; j++) begin
				rr = r + i - HALF;
				cc = c + j - HALF;
				// zero padding outside the frame
				if (rr >= 0 && cc >= 0 && rr < h && cc < w)
					acc += longint'(frame_pix[rr * w + cc]) * longint'(kernel_taps[i * KSZ + j]);
			end
		res.out_value = acc[OUT_BITS-1:0];
		res.out_last  = (idx == w * h - 1);
		return res;
	endfunction

	function automatic void predict_outputs(input in_req_t req);
		int w, total, lag, idx;
		if (req.operation == OP_COEF) begin
			if (req.coef_index < TAPS)
				kernel_taps[req.coef_index] = req.coef_value;
		end else begin
			w     = cols_of(img_w_raw);
			total = w * rows_of(img_h_raw);
			lag   = HALF * w + HALF;
			frame_pix[pix_pos] = req.pixel_value;
			if (pix_pos == total - 1) begin
				// last pixel flushes everything still owed for the frame
				for (idx = (pix_pos >= lag) ? pix_pos - lag : 0; idx < total; idx++)
					expected_results.push_back(conv_at(idx));
				pix_pos = 0;
			end else begin
				if (pix_pos >= lag)
					expected_results.push_back(conv_at(pix_pos - lag));
				pix_pos++;
			end
		end
	endfunction

	function automatic int pick_gap();
		int roll;
		if (!idle_enable)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_BITS-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return DIM_BITS'($urandom_range(0, 2));
			1: return DIM_BITS'($urandom_range(10, 63));
			default: return DIM_BITS'($urandom_range(3, 9));
		endcase
	endfunction

	function automatic in_req_t make_pixel(input logic [15:0] val);
		in_req_t req;
		req.operation   = OP_PIXEL;
		req.coef_index  = IDX_BITS'($urandom_range(0, 15));
		req.coef_value  = rand_word();
		req.pixel_value = val;
		return req;
	endfunction

	function automatic in_req_t make_coef(input logic [IDX_BITS-1:0] idx, input logic [15:0] val);
		in_req_t req;
		req.operation   = OP_COEF;
		req.coef_index  = idx;
		req.coef_value  = val;
		req.pixel_value = rand_word();
		return req;
	endfunction

	// one request: optional gap, then hold it until accepted
	task automatic send_req(input in_req_t req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		predict_outputs(req);
		accepted_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		// coefficient loads and partial frames leave nothing to wait on
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [DIM_BITS-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			img_w_raw = val;
		else
			img_h_raw = val;
		pix_pos = 0;
		geometry_writes++;
	endtask

	task automatic set_geometry(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	task automatic send_coef_random(inout int sent);
		logic [IDX_BITS-1:0] idx;
		if ($urandom_range(0, 7) == 0)
			idx = IDX_BITS'($urandom_range(TAPS, (1 << IDX_BITS) - 1));
		else
			idx = IDX_BITS'($urandom_range(0, TAPS - 1));
		send_req(make_coef(idx, rand_word()));
		if (idx < TAPS)
			sent++;
	endtask

	task automatic send_pixels(input int count, inout int sent);
		for (int p = 0; p < count; p++) begin
			if ($urandom_range(0, 15) == 0)
				send_coef_random(sent);
			send_req(make_pixel(rand_word()));
			sent++;
		end
	endtask

	// extreme coefficients and pixels, ignored indexes, 1x1 frame from zero geometry
	task automatic test_directed();
		logic [15:0] tap_vals [TAPS] = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000,
			16'h2000, 16'hE000, 16'h3039, 16'h8000};
		logic [15:0] pix_vals [9] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0001,
			16'h0100, 16'h8000, 16'h7FFF, 16'h5A5A};
		set_geometry(DIM_BITS'(3), DIM_BITS'(3));
		for (int i = 0; i < TAPS; i++)
			send_req(make_coef(IDX_BITS'(i), tap_vals[i]));
		send_req(make_coef(IDX_BITS'(TAPS), 16'h7FFF));
		send_req(make_coef(IDX_BITS'((1 << IDX_BITS) - 1), 16'h8000));
		for (int i = 0; i < 9; i++)
			send_req(make_pixel(pix_vals[i]));
		set_geometry('0, '0);
		send_req(make_pixel(16'h8000));
	endtask

	// register write in the middle of a frame restarts it
	task automatic test_frame_drop();
		int sent;
		sent = 0;
		set_geometry(DIM_BITS'(4), DIM_BITS'(4));
		send_pixels(7, sent);
		wait_drained();
		write_reg(REG_IMAGE_HEIGHT, DIM_BITS'(3));
		send_pixels(12, sent);
	endtask

	// sink holds off while the source streams back to back
	task automatic test_backpressure();
		set_geometry(DIM_BITS'(8), DIM_BITS'(6));
		idle_enable = 1'b0;
		for (int i = 0; i < TAPS; i++)
			send_req(make_coef(IDX_BITS'(i), 16'h8000));
		long_hold_requests++;
		// top half most negative, bottom half most positive: extreme window sums
		for (int p = 0; p < 48; p++)
			send_req(make_pixel((p < 24) ? 16'h8000 : 16'h7FFF));
		wait_drained();
		idle_enable = 1'b1;
	endtask

	task automatic test_random_frames();
		logic [DIM_BITS-1:0] corner_w [3] = '{6'd63, 6'd0, 6'd33};
		logic [DIM_BITS-1:0] corner_h [3] = '{6'd1, 6'd63, 6'd2};
		logic [DIM_BITS-1:0] w_raw, h_raw;
		int sent, setting, frames, total, count;
		sent    = 0;
		setting = 0;
		while (sent < RANDOM_ITEMS) begin
			if (setting < 3) begin
				w_raw  = corner_w[setting];
				h_raw  = corner_h[setting];
				frames = 1;
			end else begin
				w_raw = pick_dim();
				h_raw = pick_dim();
				if (cols_of(w_raw) * rows_of(h_raw) > 120)
					h_raw = DIM_BITS'(120 / cols_of(w_raw));
				frames = $urandom_range(1, 2);
			end
			set_geometry(w_raw, h_raw);
			total = cols_of(w_raw) * rows_of(h_raw);
			for (int f = 0; f < frames; f++) begin
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, TAPS)) send_coef_random(sent);
				count = total;
				// now and then abandon a frame; the next register write drops it
				if (setting >= 3 && total > 1 && $urandom_range(0, 9) == 0)
					count = $urandom_range(1, total - 1);
				send_pixels(count, sent);
				if (count < total)
					break;
			end
			setting++;
		end
	endtask

	// result sink: random stalls plus on-request long hold
	int hold_left = 0;
	int stall_run = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end else if (long_holds_served != long_hold_requests) begin
			long_holds_served = long_hold_requests;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
		end else begin
			stall_run = pick_gap();
			out_stall <= (stall_run > 0);
			if (stall_run > 0)
				stall_run--;
		end
	end

	always @(posedge clk) begin
		out_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("out_value: unexpected result %0d, nothing pending", out_data.out_value);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (out_data.out_value !== want.out_value) begin
					$error("out_value: expected %0d, got %0d", want.out_value,
						out_data.out_value);
					mismatch_count++;
				end
				if (out_data.out_last !== want.out_last) begin
					$error("out_last: expected %0b, got %0b", want.out_last, out_data.out_last);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count,
				expected_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		foreach (kernel_taps[i])
			kernel_taps[i] = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_frame_drop();
		test_backpressure();
		test_random_frames();
		wait_drained();

		if (expected_results.size() != 0) begin
			$error("out_value: %0d expected results never arrived", expected_results.size());
			mismatch_count++;
		end
		$display("Run covered %0d accepted requests and %0d checked results",
			accepted_count, results_checked);
		$display("over %0d register writes, with a dropped frame, a %0d-cycle output hold",
			geometry_writes, LONG_HOLD);
		$display("and out-of-range geometry.");
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
